### rtl/core/lrw_pkg.sv
// Shared types and constants for the line raster walker.
package lrw_pkg;

  localparam int CANVAS_SIZE = 64;
  localparam int COORD_W     = 6;
  localparam int DIM_W       = 7;
  localparam int GAIN_W      = 10;
  localparam int LEVEL_W     = 8;
  localparam int ERR_W       = 8;
  localparam int PROD_W      = LEVEL_W + GAIN_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 10;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  // level*gain at or above 255*256 divides to 256 or more and saturates
  localparam logic [PROD_W-1:0]  PROD_SAT  = PROD_W'(255 * 256);

  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_INTENSITY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCALE,
    ST_WALK
  } state_t;

  typedef struct packed {
    logic load;
    logic scale;
    logic step;
  } lrw_cmd_t;

  typedef struct packed {
    logic last;
  } lrw_status_t;

endpackage

### rtl/core/lrw_ctrl.sv
// Sequencer for the line walk: load, scale, then one point per word.
module lrw_ctrl import lrw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output lrw_cmd_t    cmd,
  input  lrw_status_t status
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/lrw_datapath.sv
// Walk registers, Bresenham error update and level scaling.
module lrw_datapath import lrw_pkg::*; (
  input  logic               clk,
  input  lrw_cmd_t           cmd,
  output lrw_status_t        status,
  input  logic [COORD_W-1:0] start_x,
  input  logic [COORD_W-1:0] start_y,
  input  logic [COORD_W-1:0] end_x,
  input  logic [COORD_W-1:0] end_y,
  input  logic [LEVEL_W-1:0] line_level,
  input  logic [DIM_W-1:0]   canvas_width,
  input  logic [DIM_W-1:0]   canvas_height,
  input  logic [GAIN_W-1:0]  light_intensity,
  output logic [COORD_W-1:0] point_x,
  output logic [COORD_W-1:0] point_y,
  output logic               inside_res,
  output logic [LEVEL_W-1:0] pixel_level,
  output logic               last_point
);

  logic [COORD_W-1:0]      cur_x, cur_y, target_x, target_y, span_x, span_y;
  logic                    step_x_neg, step_y_neg;
  logic signed [ERR_W-1:0] error_term;
  logic [LEVEL_W-1:0]      scaled_level;
  logic [PROD_W-1:0]       product;

  // load-time span and initial error
  logic [COORD_W-1:0]      ld_span_x, ld_span_y;
  logic signed [ERR_W-1:0] ld_err;

  always_comb begin
    ld_span_x = (start_x < end_x) ? end_x - start_x : start_x - end_x;
    ld_span_y = (start_y < end_y) ? end_y - start_y : start_y - end_y;
    if (ld_span_x > ld_span_y) begin
      ld_err = signed'(ERR_W'(ld_span_x >> 1));
    end else begin
      ld_err = -signed'(ERR_W'(ld_span_y >> 1));
    end
  end

  // divide by 255 as (p + p/256 + 1)/256, exact for p below 2^16 - 1
  logic [PROD_W-1:0] quot_sum;
  logic [LEVEL_W-1:0] level_calc;

  always_comb begin
    quot_sum = product + (product >> 8) + PROD_W'(1);
    if (product >= PROD_SAT) begin
      level_calc = LEVEL_MAX;
    end else begin
      level_calc = quot_sum[LEVEL_W+7:8];
    end
  end

  // error step, one guard bit
  logic signed [ERR_W:0] e9, dx9, dy9, e_new;
  logic                  take_x, take_y;

  always_comb begin
    e9     = (ERR_W+1)'(error_term);
    dx9    = signed'({{(ERR_W+1-COORD_W){1'b0}}, span_x});
    dy9    = signed'({{(ERR_W+1-COORD_W){1'b0}}, span_y});
    take_x = e9 > -dx9;
    take_y = e9 < dy9;
    e_new  = e9 - (take_x ? dy9 : '0) + (take_y ? dx9 : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x      <= start_x;
      cur_y      <= start_y;
      target_x   <= end_x;
      target_y   <= end_y;
      span_x     <= ld_span_x;
      span_y     <= ld_span_y;
      step_x_neg <= !(start_x < end_x);
      step_y_neg <= !(start_y < end_y);
      error_term <= ld_err;
      product    <= line_level * light_intensity;
    end
    if (cmd.scale) begin
      scaled_level <= level_calc;
    end
    if (cmd.step) begin
      error_term <= e_new[ERR_W-1:0];
      if (take_x) begin
        cur_x <= step_x_neg ? cur_x - COORD_W'(1) : cur_x + COORD_W'(1);
      end
      if (take_y) begin
        cur_y <= step_y_neg ? cur_y - COORD_W'(1) : cur_y + COORD_W'(1);
      end
    end
  end

  logic [DIM_W-1:0] wlim, hlim;

  always_comb begin
    wlim = (canvas_width > DIM_W'(CANVAS_SIZE)) ? DIM_W'(CANVAS_SIZE) : canvas_width;
    hlim = (canvas_height > DIM_W'(CANVAS_SIZE)) ? DIM_W'(CANVAS_SIZE) : canvas_height;
  end

  assign status.last = (cur_x == target_x) && (cur_y == target_y);
  assign point_x     = cur_x;
  assign point_y     = cur_y;
  assign inside_res  = ({1'b0, cur_x} < wlim) && ({1'b0, cur_y} < hlim);
  assign pixel_level = scaled_level;
  assign last_point  = status.last;

endmodule

### rtl/core/line_raster_walker.sv
// Top level of the line raster walker: config registers, sequencer and datapath.
//
// One input word is a line request (two end points and a grey level); the block
// answers with one output word per point of the line, in walk order from the
// start point to the end point, N = max(|dx|,|dy|)+1 words, at most 64. The
// request is taken in an idle cycle that also forms the gain product; a scale
// state then divides by 255 with saturation, and then points leave one per cycle
// while the output side is ready. The walk stepper holds one line at a time, so
// the next request is taken the cycle after the last point leaves.
// Each point carries an inside flag against the canvas size registers (values
// above 64 act as 64, zero marks every point outside) and last_point on the end
// point. Config writes are always taken and should only be made while idle;
// indexes past the register list are ignored.
module line_raster_walker import lrw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // config write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // line request
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_W-1:0]    start_x,
  input  logic [COORD_W-1:0]    start_y,
  input  logic [COORD_W-1:0]    end_x,
  input  logic [COORD_W-1:0]    end_y,
  input  logic [LEVEL_W-1:0]    line_level,
  // point stream
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_W-1:0]    point_x,
  output logic [COORD_W-1:0]    point_y,
  output logic                  inside_res,
  output logic [LEVEL_W-1:0]    pixel_level,
  output logic                  last_point
);

  logic [DIM_W-1:0]  canvas_width, canvas_height;
  logic [GAIN_W-1:0] light_intensity;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= DIM_W'(64);
      canvas_height   <= DIM_W'(64);
      light_intensity <= GAIN_W'(255);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CANVAS_WIDTH:    canvas_width    <= cfg_data[DIM_W-1:0];
        CFG_CANVAS_HEIGHT:   canvas_height   <= cfg_data[DIM_W-1:0];
        CFG_LIGHT_INTENSITY: light_intensity <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  lrw_cmd_t    cmd;
  lrw_status_t status;

  lrw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  lrw_datapath u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .status          (status),
    .start_x         (start_x),
    .start_y         (start_y),
    .end_x           (end_x),
    .end_y           (end_y),
    .line_level      (line_level),
    .canvas_width    (canvas_width),
    .canvas_height   (canvas_height),
    .light_intensity (light_intensity),
    .point_x         (point_x),
    .point_y         (point_y),
    .inside_res      (inside_res),
    .pixel_level     (pixel_level),
    .last_point      (last_point)
  );

endmodule

### tb/sv/line_raster_walker_tb.sv
// Self-checking testbench for the line raster walker: line requests in, checked points out.
module line_raster_walker_tb import lrw_pkg::*; ();

  // One point of a walked line, in the order the block should emit it.
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               on_canvas;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } point_t;

  localparam int LONG_STALL   = 300;     // receiver hold-off used to back up the block
  localparam int DRAIN_GUARD  = 200000;  // cycles allowed for outstanding points to drain
  localparam int MAX_REPORTED = 40;      // mismatch lines printed before going quiet

  // register index past the end of the list
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Every block input starts at a known value.
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [COORD_W-1:0]    start_x   = '0;
  logic [COORD_W-1:0]    start_y   = '0;
  logic [COORD_W-1:0]    end_x     = '0;
  logic [COORD_W-1:0]    end_y     = '0;
  logic [LEVEL_W-1:0]    line_level = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COORD_W-1:0]    point_x;
  logic [COORD_W-1:0]    point_y;
  logic                  inside_res;
  logic [LEVEL_W-1:0]    pixel_level;
  logic                  last_point;

  // Shadow copy of the config registers, updated when a write is taken.
  logic [DIM_W-1:0]  canvas_w = 7'd64;
  logic [DIM_W-1:0]  canvas_h = 7'd64;
  logic [GAIN_W-1:0] gain     = 10'd255;

  point_t points_due[$];   // points still owed by the block, oldest first

  int send_idle_pct = 0;   // chance per cycle that the sender holds back a word
  int recv_idle_pct = 0;   // chance per cycle that the receiver drops ready
  int stalls_asked  = 0;   // bumped by a test to request one long hold-off
  int stalls_done   = 0;
  int stall_left    = 0;

  int mismatch_count = 0;
  int lines_sent     = 0;
  int points_checked = 0;
  int cfg_writes     = 0;

  line_raster_walker i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .line_level  (line_level),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .point_x     (point_x),
    .point_y     (point_y),
    .inside_res  (inside_res),
    .pixel_level (pixel_level),
    .last_point  (last_point)
  );

  always #1 clk = ~clk;

  // Watchdog: far beyond the slowest legal run, every line at 64 points and
  // the receiver idling most of the time.
  initial begin
    #2000000;
    $display("timeout: %0d points still outstanding", points_due.size());
    $display("** line_raster_walker: FAILED **");
    $finish;
  end

  task automatic note_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_REPORTED) begin
      $display("mismatch at point %0d: %s got %0d expected %0d",
               points_checked, what, got, want);
    end
    mismatch_count++;
  endtask

  // Walk the line the way the block should: Bresenham with the error term
  // seeded at half the major span (negative when y is major), one point per
  // step until the end point, which is marked last.
  task automatic plot_line_points(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                                  input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                                  input logic [LEVEL_W-1:0] lvl);
    int     cx, cy, dx, dy, err, e, wlim, hlim, scaled, n;
    bit     neg_x, neg_y;
    point_t p;
    cx = sx;
    cy = sy;
    neg_x = !(sx < ex);
    neg_y = !(sy < ey);
    dx = (sx < ex) ? ex - sx : sx - ex;
    dy = (sy < ey) ? ey - sy : sy - ey;
    err = (dx > dy) ? dx / 2 : -(dy / 2);
    // canvas registers above the canvas size clamp to it
    wlim = (canvas_w > CANVAS_SIZE) ? CANVAS_SIZE : canvas_w;
    hlim = (canvas_h > CANVAS_SIZE) ? CANVAS_SIZE : canvas_h;
    scaled = (int'(lvl) * int'(gain)) / 255;
    if (scaled > 255) scaled = 255;
    n = 0;
    while (n < 64) begin
      e = err;
      p.x = cx[COORD_W-1:0];
      p.y = cy[COORD_W-1:0];
      p.on_canvas = (cx < wlim) && (cy < hlim);
      p.level = scaled[LEVEL_W-1:0];
      p.last = (cx == ex) && (cy == ey);
      points_due = {points_due, p};
      n++;
      if (p.last) break;
      if (e > -dx) begin
        err -= dy;
        cx = neg_x ? ((cx - 1) & 63) : ((cx + 1) & 63);
      end
      if (e < dy) begin
        err += dx;
        cy = neg_y ? ((cy - 1) & 63) : ((cy + 1) & 63);
      end
    end
  endtask

  // Offer one line request. Called at a rising edge; returns at the edge that
  // took the word, leaving valid high so back-to-back words need no re-raise.
  task automatic send_line(input int sx, input int sy, input int ex, input int ey, input int lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    start_x    <= sx[COORD_W-1:0];
    start_y    <= sy[COORD_W-1:0];
    end_x      <= ex[COORD_W-1:0];
    end_y      <= ey[COORD_W-1:0];
    line_level <= lvl[LEVEL_W-1:0];
    do @(posedge clk); while (!in_ready);
    plot_line_points(sx[COORD_W-1:0], sy[COORD_W-1:0], ex[COORD_W-1:0], ey[COORD_W-1:0],
                     lvl[LEVEL_W-1:0]);
    lines_sent++;
  endtask

  // Stop offering lines, let every owed point come out, then wait for the
  // walker to fall back to idle. Config writes only follow this.
  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    while (points_due.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  // Once the write is taken, drops valid and updates the shadow copy before returning.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CANVAS_WIDTH:    canvas_w = value[DIM_W-1:0];
      CFG_CANVAS_HEIGHT:   canvas_h = value[DIM_W-1:0];
      CFG_LIGHT_INTENSITY: gain     = value[GAIN_W-1:0];
      default: ;  // unmapped index: the block drops it
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  // Receiver: random ready, or a counted hold-off when a test asks for one.
  always @(posedge clk) begin
    if (stalls_asked != stalls_done) begin
      stall_left = LONG_STALL;
      stalls_done++;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Every point word taken is matched against the oldest owed point.
  always @(posedge clk) begin
    point_t want;
    if (!rst && out_valid && out_ready) begin
      if (points_due.size() == 0) begin
        note_mismatch("unexpected point, x", point_x, -1);
      end else begin
        want = points_due.pop_front();
        if (point_x != want.x) note_mismatch("point_x", point_x, want.x);
        if (point_y != want.y) note_mismatch("point_y", point_y, want.y);
        if (inside_res != want.on_canvas) note_mismatch("inside_res", inside_res, want.on_canvas);
        if (pixel_level != want.level) note_mismatch("pixel_level", pixel_level, want.level);
        if (last_point != want.last) note_mismatch("last_point", last_point, want.last);
      end
      points_checked++;
    end
  end

  // Corners, diagonals both ways, axis-aligned lines, single points and the
  // steep/shallow split, at reset config.
  task automatic test_directed_lines();
    send_line(0, 0, 0, 0, 0);
    send_line(63, 63, 63, 63, 255);
    send_line(0, 0, 63, 63, 128);
    send_line(63, 63, 0, 0, 1);
    send_line(63, 0, 0, 63, 200);
    send_line(0, 63, 63, 0, 77);
    send_line(0, 5, 63, 5, 255);
    send_line(7, 63, 7, 0, 64);
    send_line(3, 10, 5, 50, 170);
    send_line(50, 12, 10, 15, 85);
    send_line(20, 20, 21, 22, 254);
    send_line(42, 21, 21, 42, 42);
    settle();
  endtask

  // Tiny canvas, empty canvas, oversize registers (clamped) and an unmapped
  // register index that must change nothing.
  task automatic test_canvas_limits();
    write_reg(CFG_CANVAS_WIDTH, 1);
    write_reg(CFG_CANVAS_HEIGHT, 1);
    send_line(0, 0, 5, 1, 100);
    settle();
    write_reg(CFG_CANVAS_WIDTH, 0);
    write_reg(CFG_CANVAS_HEIGHT, 0);
    send_line(0, 0, 3, 3, 10);
    settle();
    write_reg(CFG_CANVAS_WIDTH, 'h3C5);   // low seven bits are 69, past the canvas
    write_reg(CFG_CANVAS_HEIGHT, 65);
    write_reg(CFG_UNMAPPED, 'h2AA);
    send_line(0, 63, 63, 0, 33);
    settle();
    write_reg(CFG_CANVAS_WIDTH, 63);
    write_reg(CFG_CANVAS_HEIGHT, 32);
    send_line(60, 30, 63, 34, 250);
    settle();
  endtask

  // Zero gain, full gain with saturation and a gain just above unity, then the reset config again.
  task automatic test_gain_extremes();
    write_reg(CFG_LIGHT_INTENSITY, 0);
    send_line(1, 1, 2, 2, 255);
    settle();
    write_reg(CFG_LIGHT_INTENSITY, 1023);
    send_line(10, 0, 12, 0, 255);
    send_line(10, 1, 12, 1, 64);
    send_line(10, 2, 12, 2, 63);
    settle();
    write_reg(CFG_LIGHT_INTENSITY, 256);
    send_line(0, 9, 0, 11, 254);
    settle();
    write_reg(CFG_CANVAS_WIDTH, 64);
    write_reg(CFG_CANVAS_HEIGHT, 64);
    write_reg(CFG_LIGHT_INTENSITY, 255);
  endtask

  // Hold the receiver off long enough that the walker fills and drops
  // in_ready, while the sender keeps a word on offer the whole time.
  task automatic test_output_backpressure();
    int saved;
    saved = send_idle_pct;
    send_idle_pct = 0;
    stalls_asked++;
    repeat (8) begin
      send_line($urandom_range(63), $urandom_range(63), $urandom_range(63),
                $urandom_range(63), $urandom_range(255));
    end
    send_idle_pct = saved;
    settle();
  endtask

  // Random lines in blocks, each block under a fresh config picked from the
  // extremes and random values. Most lines are short so the run stays brisk.
  task automatic test_random_lines(input int count, input int send_pct, input int recv_pct);
    int sx, sy, ex, ey, pick, k;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (k = 0; k < count; k++) begin
      if (k % 40 == 0) begin
        settle();
        pick = $urandom_range(5);
        write_reg(CFG_CANVAS_WIDTH, pick == 0 ? 0 : pick == 1 ? 1 : pick == 2 ? 64 :
                  pick == 3 ? 127 : $urandom_range(1023));
        pick = $urandom_range(5);
        write_reg(CFG_CANVAS_HEIGHT, pick == 0 ? 0 : pick == 1 ? 1 : pick == 2 ? 64 :
                  pick == 3 ? 127 : $urandom_range(1023));
        pick = $urandom_range(5);
        write_reg(CFG_LIGHT_INTENSITY, pick == 0 ? 0 : pick == 1 ? 255 : pick == 2 ? 1023 :
                  $urandom_range(1023));
      end
      sx = $urandom_range(63);
      sy = $urandom_range(63);
      pick = $urandom_range(99);
      if (pick < 5) begin
        ex = sx;
        ey = sy;
      end else if (pick < 75) begin
        ex = $urandom_range(sx > 52 ? 63 : sx + 11, sx < 11 ? 0 : sx - 11);
        ey = $urandom_range(sy > 52 ? 63 : sy + 11, sy < 11 ? 0 : sy - 11);
      end else begin
        ex = $urandom_range(63);
        ey = $urandom_range(63);
      end
      send_line(sx, sy, ex, ey, $urandom_range(255));
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 26;
    recv_idle_pct = 85;
    test_directed_lines();
    test_canvas_limits();
    test_gain_extremes();
    test_output_backpressure();

    // sender light / receiver heavy, then the reverse, then flat out
    test_random_lines(170, 26, 85);
    test_random_lines(170, 85, 26);
    test_random_lines(170, 0, 0);

    if (points_due.size() != 0) begin
      note_mismatch("points never delivered", 0, points_due.size());
    end
    $display("covered %0d lines, %0d points checked, %0d register writes",
             lines_sent, points_checked, cfg_writes);
    $display("canvas clamping, empty canvas, gain saturation and a long output stall included");
    if (mismatch_count == 0) begin
      $display("** line_raster_walker: PASSED **");
    end else begin
      $display("** line_raster_walker: FAILED **");
    end
    $finish;
  end

endmodule
